[src/sid_pkg.sv]
// Shared types and constants for the scaled image difference error block.
package sid_pkg;

   localparam int MAX_SCALE_DEF = 16;
   localparam int ACC_BITS_DEF  = 48;

   localparam int PIX_W      = 8;
   localparam int DIFF_W     = 8;
   localparam int ROOT_W     = 30;
   localparam int FRAC_BITS  = 8;
   localparam int CSR_ADDR_W = 1;
   localparam int CSR_DATA_W = 5;
   localparam int SCALE_W    = 5;

   localparam int GRP_VAL_W   = 16;
   localparam int GRP_SCALE_W = 7;

   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_PTR_W = 2;

   localparam logic [ROOT_W-1:0] ROOT_MAX = '1;

   localparam logic [CSR_ADDR_W-1:0] REG_DIFF_MODE = 1'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_SCALE_X   = 1'd1;

   typedef enum logic [1:0] {
      MODE_FIRST = 2'd0,
      MODE_AVG   = 2'd1,
      MODE_MAX   = 2'd2,
      MODE_MIN   = 2'd3
   } diff_mode_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MAG,
      ST_GDIV,
      ST_ACC,
      ST_ROOT,
      ST_RDIV,
      ST_OUT
   } back_state_type;

   typedef struct packed {
      logic signed [GRP_VAL_W-1:0] value;
      logic                        avg;
      logic [GRP_SCALE_W-1:0]      scale;
      logic                        last;
   } group_rec_type;

endpackage

[src/scaled_image_diff_error.sv]
// Flow: each group passes magnitude, accumulate and output states (and a divide in average mode);
// the frame's last group adds the bit-serial square root, then a root divide in average mode.
// Throughput: one pixel per cycle while the 4-entry group queue has room; the back end
// retires one group at a time, and in average mode waits on the shared bit-serial divider.
// Reset: synchronous, active high; clears the queue, counters, accumulator and result valid,
// and sets diff_mode to first pixel and scale_x to 1.
module scaled_image_diff_error #(
   parameter int MAX_SCALE = sid_pkg::MAX_SCALE_DEF,
   parameter int ACC_BITS  = sid_pkg::ACC_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic [sid_pkg::CSR_ADDR_W-1:0]  csr_addr,
   input  logic [sid_pkg::CSR_DATA_W-1:0]  csr_wdata,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [15:0]                     req_tdata,   // small_pixel[7:0], big_pixel[15:8]
   input  logic                            req_tlast,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [39:0]                     rsp_tdata,   // diff_pixel[7:0], root_error[37:8], zero
   output logic                            rsp_tlast
);
   import sid_pkg::*;

   logic                push;
   group_rec_type       push_data;
   logic                fifo_full;
   logic                pop;
   group_rec_type       pop_data;
   logic                fifo_empty;
   logic [DIFF_W-1:0]   rsp_diff;
   logic [ROOT_W-1:0]   rsp_root;

   sid_front #(
      .MAX_SCALE (MAX_SCALE)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .csr_we        (csr_we),
      .csr_addr      (csr_addr),
      .csr_wdata     (csr_wdata),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .small_pixel   (req_tdata[7:0]),
      .big_pixel     (req_tdata[15:8]),
      .last_in_frame (req_tlast),
      .fifo_full     (fifo_full),
      .push          (push),
      .push_data     (push_data)
   );

   sid_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (fifo_full),
      .pop       (pop),
      .pop_data  (pop_data),
      .empty     (fifo_empty)
   );

   sid_back #(
      .MAX_SCALE (MAX_SCALE),
      .ACC_BITS  (ACC_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .fifo_empty (fifo_empty),
      .fifo_data  (pop_data),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_diff   (rsp_diff),
      .rsp_last   (rsp_tlast),
      .rsp_root   (rsp_root)
   );

   assign rsp_tdata = {2'b00, rsp_root, rsp_diff};

endmodule

[src/sid_front.sv]
// Front end: configuration registers, per-pixel group tracking and group record push.
module sid_front #(
   parameter int MAX_SCALE = sid_pkg::MAX_SCALE_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [sid_pkg::CSR_ADDR_W-1:0]      csr_addr,
   input  logic [sid_pkg::CSR_DATA_W-1:0]      csr_wdata,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [sid_pkg::PIX_W-1:0]           small_pixel,
   input  logic [sid_pkg::PIX_W-1:0]           big_pixel,
   input  logic                                last_in_frame,
   input  logic                                fifo_full,
   output logic                                push,
   output sid_pkg::group_rec_type              push_data
);
   import sid_pkg::*;

   localparam int SC_W  = $clog2(MAX_SCALE + 1);
   localparam int SUM_W = $clog2(MAX_SCALE * 255 + 1) + 1;

   diff_mode_type          mode_ff, mode_in;
   logic [SCALE_W-1:0]     scale_ff, scale_in;
   logic [SC_W-1:0]        pos_ff, pos_in;
   logic signed [SUM_W-1:0] sum_ff, sum_in;
   logic signed [8:0]      chosen_ff, chosen_in;

   logic                   accept;
   logic                   first;
   logic                   grp_done;
   logic [SC_W-1:0]        eff_scale;
   logic [SC_W-1:0]        pos_inc;
   logic signed [8:0]      d_bs;
   logic signed [8:0]      d_sb;

   function automatic logic [8:0] mag9(input logic signed [8:0] v);
      return v[8] ? 9'(-v) : 9'(v);
   endfunction

   assign req_tready = !fifo_full;
   assign accept     = req_tvalid && req_tready;
   assign first      = (pos_ff == '0);
   assign pos_inc    = pos_ff + SC_W'(1);
   assign d_bs       = signed'({1'b0, big_pixel}) - signed'({1'b0, small_pixel});
   assign d_sb       = signed'({1'b0, small_pixel}) - signed'({1'b0, big_pixel});

   always_comb begin
      if (scale_ff == '0) begin
         eff_scale = SC_W'(1);
      end else if (int'(scale_ff) > MAX_SCALE) begin
         eff_scale = SC_W'(MAX_SCALE);
      end else begin
         eff_scale = SC_W'(scale_ff);
      end
   end

   assign grp_done = (pos_inc >= eff_scale);

   always_comb begin
      mode_in   = mode_ff;
      scale_in  = scale_ff;
      pos_in    = pos_ff;
      sum_in    = sum_ff;
      chosen_in = chosen_ff;

      if (csr_we) begin
         case (csr_addr)
            REG_DIFF_MODE: mode_in  = diff_mode_type'(csr_wdata[1:0]);
            REG_SCALE_X:   scale_in = csr_wdata;
            default: ;
         endcase
      end

      if (accept) begin
         sum_in = (first ? SUM_W'(0) : sum_ff) + SUM_W'(d_bs);
         if (first) begin
            chosen_in = (mode_ff == MODE_FIRST) ? d_bs : d_sb;
         end else if (mode_ff == MODE_MAX && mag9(d_sb) > mag9(chosen_ff)) begin
            chosen_in = d_sb;
         end else if (mode_ff == MODE_MIN && mag9(d_sb) < mag9(chosen_ff)) begin
            chosen_in = d_sb;
         end
         pos_in = grp_done ? '0 : pos_inc;
      end
   end

   always_comb begin
      push            = accept && grp_done;
      push_data.value = (mode_ff == MODE_AVG) ? GRP_VAL_W'(sum_in) : GRP_VAL_W'(chosen_in);
      push_data.avg   = (mode_ff == MODE_AVG);
      push_data.scale = GRP_SCALE_W'(eff_scale);
      push_data.last  = last_in_frame;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_FIRST;
         scale_ff  <= SCALE_W'(1);
         pos_ff    <= '0;
         sum_ff    <= '0;
         chosen_ff <= '0;
      end else begin
         mode_ff   <= mode_in;
         scale_ff  <= scale_in;
         pos_ff    <= pos_in;
         sum_ff    <= sum_in;
         chosen_ff <= chosen_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_push_room: assert property (@(posedge clock) disable iff (reset)
      push |-> !fifo_full)
      else $error("group record pushed into full queue");
`endif

endmodule

[src/sid_fifo.sv]
// Short queue of group records between the front end and the back end.
module sid_fifo (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  sid_pkg::group_rec_type  push_data,
   output logic                    full,
   input  logic                    pop,
   output sid_pkg::group_rec_type  pop_data,
   output logic                    empty
);
   import sid_pkg::*;

   group_rec_type           mem_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [FIFO_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [FIFO_PTR_W:0]     count_ff, count_in;

   assign full     = (count_ff == (FIFO_PTR_W + 1)'(FIFO_DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + FIFO_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + FIFO_PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + (FIFO_PTR_W + 1)'(1);
      end else if (pop && !push) begin
         count_in = count_ff - (FIFO_PTR_W + 1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty)
      else $error("pop from empty queue");
`endif

endmodule

[src/sid_div.sv]
// Shared restoring divider, one quotient bit per cycle, by the group scale.
module sid_div #(
   parameter int DIV_W   = 32,
   parameter int SC_W    = 5,
   parameter int SHORT_W = sid_pkg::DIFF_W
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic             quot8,
   input  logic [DIV_W-1:0] dividend,
   input  logic [SC_W-1:0]  divisor,
   output logic             busy,
   output logic             done,
   output logic [DIV_W-1:0] quotient
);
   import sid_pkg::*;

   localparam int CNT_W = $clog2(DIV_W + 1);

   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [SC_W-1:0]  rem_ff, rem_in;
   logic [DIV_W-1:0] q_ff, q_in;
   logic [SC_W-1:0]  dvs_ff, dvs_in;
   logic             done_ff, done_in;

   logic [SC_W:0]    trial;
   logic             ge;

   assign trial    = {rem_ff, q_ff[DIV_W-1]};
   assign ge       = (trial >= {1'b0, dvs_ff});
   assign busy     = (cnt_ff != '0);
   assign done     = done_ff;
   assign quotient = q_ff;

   always_comb begin
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      q_in    = q_ff;
      dvs_in  = dvs_ff;
      done_in = 1'b0;
      if (start) begin
         dvs_in = divisor;
         if (quot8) begin
            cnt_in = CNT_W'(SHORT_W);
            q_in   = dividend << (DIV_W - SHORT_W);
            rem_in = '0;
         end else begin
            cnt_in = CNT_W'(DIV_W);
            q_in   = dividend;
            rem_in = '0;
         end
      end else if (busy) begin
         rem_in  = ge ? SC_W'(trial - {1'b0, dvs_ff}) : SC_W'(trial);
         q_in    = {q_ff[DIV_W-2:0], ge};
         cnt_in  = cnt_ff - CNT_W'(1);
         done_in = (cnt_ff == CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      q_ff   <= q_in;
      dvs_ff <= dvs_in;
   end

endmodule

[src/sid_back.sv]
// Back end: group difference, squared-error accumulation, frame root and result register.
module sid_back #(
   parameter int MAX_SCALE = sid_pkg::MAX_SCALE_DEF,
   parameter int ACC_BITS  = sid_pkg::ACC_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          fifo_empty,
   input  sid_pkg::group_rec_type        fifo_data,
   output logic                          pop,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [sid_pkg::DIFF_W-1:0]    rsp_diff,
   output logic                          rsp_last,
   output logic [sid_pkg::ROOT_W-1:0]    rsp_root
);
   import sid_pkg::*;

   localparam int SC_W    = $clog2(MAX_SCALE + 1);
   localparam int MAG_W   = $clog2(MAX_SCALE * 255 + 1);
   localparam int SQ_W    = 2 * MAG_W;
   localparam int ROOT_IT = (ACC_BITS + 1) / 2 + FRAC_BITS;
   localparam int RAD_W   = 2 * ROOT_IT;
   localparam int REM_W   = ROOT_IT + 2;
   localparam int CNT_W   = $clog2(ROOT_IT + 1);

   back_state_type          state_ff, state_in;
   group_rec_type           rec_ff, rec_in;
   logic [SQ_W-1:0]         sq_ff, sq_in;
   logic [ACC_BITS-1:0]     acc_ff, acc_in;
   logic [RAD_W-1:0]        rad_ff, rad_in;
   logic [REM_W-1:0]        rem_ff, rem_in;
   logic [ROOT_IT-1:0]      root_ff, root_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic [DIFF_W-1:0]       diff_ff, diff_in;
   logic [ROOT_IT-1:0]      res_ff, res_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [DIFF_W-1:0]       rsp_diff_ff, rsp_diff_in;
   logic                    rsp_last_ff, rsp_last_in;
   logic [ROOT_W-1:0]       rsp_root_ff, rsp_root_in;

   logic [GRP_VAL_W-1:0]    mag_full;
   logic [MAG_W-1:0]        mag;
   logic [ACC_BITS:0]       acc_sum;
   logic [ACC_BITS-1:0]     acc_next;
   logic [REM_W-1:0]        rem_sh;
   logic [REM_W-1:0]        trial;
   logic                    ge_root;
   logic [REM_W-1:0]        rem_step;
   logic [ROOT_IT-1:0]      root_step;
   logic [DIFF_W-1:0]       q8;
   logic [ROOT_W-1:0]       root_sat;

   logic                    div_start;
   logic                    div_quot8;
   logic [ROOT_IT-1:0]      div_dividend;
   logic                    div_busy;
   logic                    div_done;
   logic [ROOT_IT-1:0]      div_quotient;

   sid_div #(
      .DIV_W   (ROOT_IT),
      .SC_W    (SC_W),
      .SHORT_W (MAG_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .quot8    (div_quot8),
      .dividend (div_dividend),
      .divisor  (SC_W'(rec_ff.scale)),
      .busy     (div_busy),
      .done     (div_done),
      .quotient (div_quotient)
   );

   assign mag_full = rec_ff.value[GRP_VAL_W-1] ? GRP_VAL_W'(-rec_ff.value)
                                               : GRP_VAL_W'(rec_ff.value);
   assign mag      = MAG_W'(mag_full);
   assign acc_sum  = {1'b0, acc_ff} + (ACC_BITS + 1)'(sq_ff);
   assign acc_next = acc_sum[ACC_BITS] ? {ACC_BITS{1'b1}} : acc_sum[ACC_BITS-1:0];

   assign rem_sh    = {rem_ff[REM_W-3:0], rad_ff[RAD_W-1 -: 2]};
   assign trial     = {root_ff, 2'b01};
   assign ge_root   = (rem_sh >= trial);
   assign rem_step  = ge_root ? rem_sh - trial : rem_sh;
   assign root_step = {root_ff[ROOT_IT-2:0], ge_root};

   assign q8       = div_quotient[DIFF_W-1:0];
   assign root_sat = (64'(res_ff) > 64'(ROOT_MAX)) ? ROOT_MAX : ROOT_W'(res_ff);

   always_comb begin
      state_in     = state_ff;
      rec_in       = rec_ff;
      sq_in        = sq_ff;
      acc_in       = acc_ff;
      rad_in       = rad_ff;
      rem_in       = rem_ff;
      root_in      = root_ff;
      cnt_in       = cnt_ff;
      diff_in      = diff_ff;
      res_in       = res_ff;
      rsp_diff_in  = rsp_diff_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_root_in  = rsp_root_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      pop          = 1'b0;
      div_start    = 1'b0;
      div_quot8    = 1'b0;
      div_dividend = '0;

      case (state_ff)
         ST_IDLE: begin
            if (!fifo_empty) begin
               pop      = 1'b1;
               rec_in   = fifo_data;
               state_in = ST_MAG;
            end
         end
         ST_MAG: begin
            sq_in = mag * mag;
            if (rec_ff.avg) begin
               div_start    = 1'b1;
               div_quot8    = 1'b1;
               div_dividend = ROOT_IT'(mag);
               state_in     = ST_GDIV;
            end else begin
               diff_in  = rec_ff.value[DIFF_W-1:0];
               state_in = ST_ACC;
            end
         end
         ST_GDIV: begin
            if (div_done) begin
               diff_in  = rec_ff.value[GRP_VAL_W-1] ? (~q8 + DIFF_W'(1)) : q8;
               state_in = ST_ACC;
            end
         end
         ST_ACC: begin
            if (rec_ff.last) begin
               acc_in   = '0;
               rad_in   = RAD_W'({acc_next, {(2 * FRAC_BITS){1'b0}}});
               rem_in   = '0;
               root_in  = '0;
               cnt_in   = CNT_W'(ROOT_IT);
               state_in = ST_ROOT;
            end else begin
               acc_in   = acc_next;
               res_in   = '0;
               state_in = ST_OUT;
            end
         end
         ST_ROOT: begin
            rad_in  = rad_ff << 2;
            rem_in  = rem_step;
            root_in = root_step;
            cnt_in  = cnt_ff - CNT_W'(1);
            if (cnt_ff == CNT_W'(1)) begin
               if (rec_ff.avg) begin
                  div_start    = 1'b1;
                  div_dividend = root_step;
                  state_in     = ST_RDIV;
               end else begin
                  res_in   = root_step;
                  state_in = ST_OUT;
               end
            end
         end
         ST_RDIV: begin
            if (div_done) begin
               res_in   = div_quotient;
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_diff_in  = diff_ff;
               rsp_last_in  = rec_ff.last;
               rsp_root_in  = rec_ff.last ? root_sat : '0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         acc_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         acc_ff       <= acc_in;
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff       <= cnt_in;
      end
      rec_ff      <= rec_in;
      sq_ff       <= sq_in;
      rad_ff      <= rad_in;
      rem_ff      <= rem_in;
      root_ff     <= root_in;
      diff_ff     <= diff_in;
      res_ff      <= res_in;
      rsp_diff_ff <= rsp_diff_in;
      rsp_last_ff <= rsp_last_in;
      rsp_root_ff <= rsp_root_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_diff   = rsp_diff_ff;
   assign rsp_last   = rsp_last_ff;
   assign rsp_root   = rsp_root_ff;

`ifndef NO_ASSERTIONS
   a_div_idle_start: assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_busy)
      else $error("divider started while busy");

   a_root_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROOT) |-> (cnt_ff != '0))
      else $error("root iteration with exhausted count");

   a_frame_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_OUT && rec_ff.last) |-> (acc_ff == '0))
      else $error("accumulator not cleared at frame end");
`endif

endmodule
